/* design/bhpd_pkg.sv */
// Shared types, character codes and hex helpers for the baggage header percent decoder.
// Used by the front, queue, back and top level modules; depends on nothing.
package bhpd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;

	localparam int QUEUE_DEPTH_DEF = 4;

	// Up to three results caused by one header byte. The pair, header and
	// malformed marks apply to the last result of the bundle only.
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            present;
		logic            inval;
		logic            pair;
		logic            hdr;
		logic            mal;
	} bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	// Letters of either case keep their value in the low nibble offset by nine.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

/* design/baggage_header_percent_decoder_core.sv */
// Top level of the baggage header percent decoder: front parser, bundle queue
// and back serializer. Depends on bhpd_pkg, bhpd_front, bhpd_queue, bhpd_back.
//
// Header bytes enter one beat per cycle through push/full and leave as decoded
// result beats through empty/pop. Each input beat is parsed in the cycle it is
// accepted and yields zero to three results; these wait as one entry in a
// queue of QUEUE_DEPTH entries, and the output register hands out one result
// per cycle while pop is held; a result is written into a queue slot and then
// loaded into the output register before it is visible. full rises only when
// the queue holds QUEUE_DEPTH bundles; the sustained rate is one input beat
// per cycle as long as the bytes give about one result each, and is set by the
// one-result-per-cycle output port when escapes or pair ends give more. After
// a header end all parser state is back at its reset value, so the next header
// may follow in the next cycle.
module baggage_header_percent_decoder_core #(
	parameter int QUEUE_DEPTH = bhpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_header,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       in_value,
	output logic       pair_done,
	output logic       header_done,
	output logic       malformed
);
	import bhpd_pkg::*;

	logic    accept;
	logic    q_push;
	bundle_t q_in;
	bundle_t q_out;
	logic    q_pop;
	logic    q_empty;

	assign accept = push && !full;

	bhpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.end_of_header(end_of_header),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	bhpd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.full  (full),
		.pop   (q_pop),
		.dout  (q_out),
		.empty (q_empty)
	);

	bhpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_out),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.byte_present(byte_present),
		.in_value    (in_value),
		.pair_done   (pair_done),
		.header_done (header_done),
		.malformed   (malformed)
	);

endmodule

/* design/bhpd_front.sv */
// Front part of the baggage header percent decoder: parses each accepted byte,
// tracks key/value phase and held escape bytes, and pushes one bundle per byte that gives results.
// Depends on bhpd_pkg.
module bhpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              end_of_header,
	output logic              q_push,
	output bhpd_pkg::bundle_t q_data
);
	import bhpd_pkg::*;

	localparam logic [1:0] PH_KEY     = 2'd0;
	localparam logic [1:0] PH_VALUE   = 2'd1;
	localparam logic [1:0] PH_DISCARD = 2'd2;

	logic [1:0] phase_q;
	logic       seg_q;
	logic [1:0] pcnt_q;
	logic [7:0] pdig_q;

	logic [1:0]      phase_n;
	logic            seg_n;
	logic [1:0]      pcnt_n;
	logic [7:0]      pdig_n;
	bundle_t         bnd;
	logic [2:0][7:0] byt;
	logic [1:0]      cnt;
	logic            take_reg;
	logic            do_flush;
	logic            flush_inval;
	logic            do_mark;
	logic            mark_hdr;
	logic            do_mal;

	always_comb begin
		phase_n     = phase_q;
		seg_n       = seg_q;
		pcnt_n      = pcnt_q;
		pdig_n      = pdig_q;
		byt         = '0;
		cnt         = 2'd0;
		take_reg    = 1'b0;
		do_flush    = 1'b0;
		flush_inval = 1'b0;
		do_mark     = 1'b0;
		mark_hdr    = 1'b0;
		do_mal      = 1'b0;
		bnd         = '0;
		bnd.present = 1'b1;

		// Classify the byte.
		if (phase_q[1]) begin
			if (end_of_header) begin
				do_mal = 1'b1;
			end
		end else if (phase_q == PH_KEY) begin
			if (data_byte == CH_COMMA || end_of_header) begin
				do_mal = 1'b1;
			end else if (data_byte == CH_EQUALS) begin
				if (!seg_q) begin
					do_mal = 1'b1;
				end else begin
					do_flush    = 1'b1;
					flush_inval = 1'b0;
					phase_n     = PH_VALUE;
					seg_n       = 1'b0;
				end
			end else begin
				take_reg = 1'b1;
			end
		end else begin
			if (data_byte == CH_COMMA) begin
				if (!seg_q) begin
					do_mal = 1'b1;
				end else begin
					do_flush    = 1'b1;
					flush_inval = 1'b1;
					do_mark     = 1'b1;
					mark_hdr    = end_of_header;
					phase_n     = PH_KEY;
					seg_n       = 1'b0;
				end
			end else begin
				take_reg = 1'b1;
			end
		end

		// Ordinary byte of a key or a value, with escape handling.
		if (take_reg) begin
			seg_n       = 1'b1;
			flush_inval = phase_q[0];
			case (pcnt_q)
				2'd0: begin
					if (data_byte == CH_PERCENT) begin
						pcnt_n = 2'd1;
					end else begin
						byt[cnt] = data_byte;
						cnt      = cnt + 2'd1;
					end
				end
				2'd1: begin
					if (is_hex(data_byte)) begin
						pdig_n = data_byte;
						pcnt_n = 2'd2;
					end else begin
						byt[cnt] = CH_PERCENT;
						cnt      = cnt + 2'd1;
						if (data_byte != CH_PERCENT) begin
							byt[cnt] = data_byte;
							cnt      = cnt + 2'd1;
							pcnt_n   = 2'd0;
						end
					end
				end
				default: begin
					pdig_n = 8'd0;
					if (is_hex(data_byte)) begin
						byt[cnt] = {hex_val(pdig_q), hex_val(data_byte)};
						cnt      = cnt + 2'd1;
						pcnt_n   = 2'd0;
					end else begin
						byt[cnt] = CH_PERCENT;
						cnt      = cnt + 2'd1;
						byt[cnt] = pdig_q;
						cnt      = cnt + 2'd1;
						if (data_byte == CH_PERCENT) begin
							pcnt_n = 2'd1;
						end else begin
							byt[cnt] = data_byte;
							cnt      = cnt + 2'd1;
							pcnt_n   = 2'd0;
						end
					end
				end
			endcase
			if (end_of_header) begin
				do_flush    = 1'b1;
				flush_inval = 1'b1;
				do_mark     = 1'b1;
				mark_hdr    = 1'b1;
			end
		end

		// Held escape bytes leave as literals at a segment end.
		if (do_flush) begin
			if (pcnt_n != 2'd0) begin
				byt[cnt] = CH_PERCENT;
				cnt      = cnt + 2'd1;
			end
			if (pcnt_n == 2'd2) begin
				byt[cnt] = pdig_n;
				cnt      = cnt + 2'd1;
			end
			pcnt_n = 2'd0;
			pdig_n = 8'd0;
		end
		bnd.inval = flush_inval;

		if (do_mark) begin
			if (cnt == 2'd0) begin
				cnt         = 2'd1;
				bnd.present = 1'b0;
			end
			bnd.inval = 1'b1;
			bnd.pair  = 1'b1;
			bnd.hdr   = mark_hdr;
			if (mark_hdr) begin
				phase_n = PH_KEY;
				seg_n   = 1'b0;
			end
		end

		if (do_mal) begin
			pcnt_n = 2'd0;
			pdig_n = 8'd0;
			if (end_of_header) begin
				cnt         = 2'd1;
				byt         = '0;
				bnd.present = 1'b0;
				bnd.inval   = 1'b0;
				bnd.pair    = 1'b0;
				bnd.hdr     = 1'b1;
				bnd.mal     = 1'b1;
				phase_n     = PH_KEY;
				seg_n       = 1'b0;
			end else begin
				phase_n = PH_DISCARD;
			end
		end

		bnd.cnt   = cnt;
		bnd.bytes = byt;
	end

	assign q_push = accept && (bnd.cnt != 2'd0);
	assign q_data = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			seg_q   <= 1'b0;
			pcnt_q  <= 2'd0;
			pdig_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			seg_q   <= seg_n;
			pcnt_q  <= pcnt_n;
			pdig_q  <= pdig_n;
		end
	end

	a_eoh_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_header |=> phase_q == PH_KEY && pcnt_q == 2'd0 && !seg_q)
		else $error("state not cleared after the last header beat");

	a_mal_single: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_data.mal |-> q_data.cnt == 2'd1 && !q_data.present && q_data.hdr)
		else $error("malformed bundle is not a single header end result");

endmodule

/* design/bhpd_queue.sv */
// Short bundle queue between the front and back parts of the decoder.
// Depends on bhpd_pkg.
module bhpd_queue #(
	parameter int DEPTH = bhpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bhpd_pkg::bundle_t din,
	output logic              full,
	input  logic              pop,
	output bhpd_pkg::bundle_t dout,
	output logic              empty
);
	import bhpd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	bundle_t          slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> count_q == FULL_CNT)
		else $error("queue lost an entry while full");

endmodule

/* design/bhpd_back.sv */
// Back part of the decoder: takes bundles from the queue and hands out their
// results one beat at a time from an output register. Depends on bhpd_pkg.
module bhpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  bhpd_pkg::bundle_t q_data,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_byte,
	output logic              byte_present,
	output logic              in_value,
	output logic              pair_done,
	output logic              header_done,
	output logic              malformed
);
	import bhpd_pkg::*;

	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       last;
	logic       taken;

	assign last  = (idx_q == cur_q.cnt - 2'd1);
	assign taken = pop && valid_q;
	assign q_pop = !q_empty && (!valid_q || (taken && last));
	assign empty = !valid_q;

	assign out_byte     = cur_q.bytes[idx_q];
	assign byte_present = cur_q.present;
	assign in_value     = cur_q.inval;
	assign pair_done    = last && cur_q.pair;
	assign header_done  = last && cur_q.hdr;
	assign malformed    = last && cur_q.mal;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (taken) begin
			if (last) begin
				valid_q <= 1'b0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < cur_q.cnt)
		else $error("result index beyond bundle size");

	a_hold_partial: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last |=> valid_q)
		else $error("bundle dropped before its last result");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for baggage_header_percent_decoder_core: directed and random
// headers, a scoreboard class that predicts each decoded beat, random push/pop idling.
// Depends on bhpd_pkg and the decoder RTL only.
module tb_top;
	import bhpd_pkg::*;

	typedef enum logic [1:0] {PH_KEY, PH_VALUE, PH_DISCARD} seg_phase_e;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       inval;
		logic       pair;
		logic       hdr;
		logic       mal;
	} beat_t;

	class pair_decode_scoreboard;
		seg_phase_e seg_phase;
		bit         seg_has_byte;
		logic [1:0] esc_held;
		logic [7:0] esc_digit;
		beat_t      expected[$];
		beat_t      burst[$];
		int         errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			seg_phase = PH_KEY;
			seg_has_byte = 1'b0;
			esc_held = 2'd0;
			esc_digit = 8'h00;
		endfunction

		function bit is_hex_digit(input logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
		endfunction

		// Folding to lower case lines both letter ranges up with 'a'.
		function logic [3:0] nibble(input logic [7:0] c);
			logic [7:0] t;
			if (c <= "9") begin
				t = c - "0";
			end else begin
				t = (c | 8'h20) - 8'h57;
			end
			return t[3:0];
		endfunction

		function void put(input logic [7:0] d, input logic iv);
			beat_t r;
			r = '{data: d, present: 1'b1, inval: iv, pair: 1'b0, hdr: 1'b0, mal: 1'b0};
			burst.push_back(r);
		endfunction

		function void flush_escape(input logic iv);
			if (esc_held >= 2'd1) put(CH_PERCENT, iv);
			if (esc_held >= 2'd2) put(esc_digit, iv);
			esc_held = 2'd0;
			esc_digit = 8'h00;
		endfunction

		function void close_pair(input logic last);
			beat_t r;
			if (burst.size() == 0) begin
				r = '{data: 8'h00, present: 1'b0, inval: 1'b1, pair: 1'b1, hdr: last, mal: 1'b0};
			end else begin
				r = burst.pop_back();
				r.pair = 1'b1;
				r.hdr = last;
			end
			burst.push_back(r);
		endfunction

		function void reject_header(input logic last);
			beat_t r;
			esc_held = 2'd0;
			esc_digit = 8'h00;
			if (last) begin
				r = '{data: 8'h00, present: 1'b0, inval: 1'b0, pair: 1'b0, hdr: 1'b1, mal: 1'b1};
				burst.push_back(r);
				restart();
			end else begin
				seg_phase = PH_DISCARD;
			end
		endfunction

		// Works out the results of one accepted header beat.
		function void note_beat(input logic [7:0] b, input logic last);
			logic iv;
			burst.delete();
			if (seg_phase != PH_KEY && seg_phase != PH_VALUE) begin
				if (last) reject_header(1'b1);
			end else begin
				iv = (seg_phase == PH_VALUE);
				if (!iv && (b == CH_COMMA || last)) begin
					reject_header(last);
				end else if (!iv && b == CH_EQUALS) begin
					if (!seg_has_byte) begin
						reject_header(last);
					end else begin
						flush_escape(1'b0);
						seg_phase = PH_VALUE;
						seg_has_byte = 1'b0;
					end
				end else if (iv && b == CH_COMMA) begin
					if (!seg_has_byte) begin
						reject_header(last);
					end else begin
						flush_escape(1'b1);
						close_pair(last);
						seg_phase = PH_KEY;
						seg_has_byte = 1'b0;
						if (last) restart();
					end
				end else begin
					seg_has_byte = 1'b1;
					case (esc_held)
						2'd0: begin
							if (b == CH_PERCENT) esc_held = 2'd1;
							else put(b, iv);
						end
						2'd1: begin
							if (is_hex_digit(b)) begin
								esc_digit = b;
								esc_held = 2'd2;
							end else begin
								put(CH_PERCENT, iv);
								if (b != CH_PERCENT) begin
									put(b, iv);
									esc_held = 2'd0;
								end
							end
						end
						default: begin
							if (is_hex_digit(b)) begin
								put({nibble(esc_digit), nibble(b)}, iv);
								esc_held = 2'd0;
							end else begin
								put(CH_PERCENT, iv);
								put(esc_digit, iv);
								if (b == CH_PERCENT) begin
									esc_held = 2'd1;
								end else begin
									put(b, iv);
									esc_held = 2'd0;
								end
							end
							if (esc_held != 2'd2) esc_digit = 8'h00;
						end
					endcase
					if (last) begin
						flush_escape(1'b1);
						close_pair(1'b1);
						restart();
					end
				end
			end
			foreach (burst[i]) expected.push_back(burst[i]);
		endfunction

		function void check_beat(input beat_t got);
			beat_t want;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: byte %02h pres %0b val %0b pair %0b hdr %0b mal %0b",
						got.data, got.present, got.inval, got.pair, got.hdr, got.mal);
			end else begin
				want = expected.pop_front();
				if (got.data !== want.data || got.present !== want.present ||
					got.inval !== want.inval || got.pair !== want.pair ||
					got.hdr !== want.hdr || got.mal !== want.mal) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %02h/%0b/%0b/%0b/%0b/%0b got %02h/%0b/%0b/%0b/%0b/%0b",
							want.data, want.present, want.inval, want.pair, want.hdr, want.mal,
							got.data, got.present, got.inval, got.pair, got.hdr, got.mal);
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       end_of_header;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       byte_present;
	logic       in_value;
	logic       pair_done;
	logic       header_done;
	logic       malformed;

	pair_decode_scoreboard sb;
	int send_idle;
	int recv_idle;
	int idle_mode;
	int beats_sent;
	logic [7:0] hdr_q[$];

	baggage_header_percent_decoder_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_header(end_of_header),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.byte_present(byte_present),
		.in_value(in_value),
		.pair_done(pair_done),
		.header_done(header_done),
		.malformed(malformed)
	);

	always #10 clk = ~clk;

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	// Handshake outputs are sampled at the falling edge, so they are settled
	// well before the rising edge that acts on them.
	task automatic send_beat(input logic [7:0] b, input logic last);
		bit took;
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_header <= last;
		do begin
			@(negedge clk);
			took = !full;
			@(posedge clk);
		end while (!took);
		sb.note_beat(b, last);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] hex_ch(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + v;
		return (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	function automatic logic [7:0] plain_ch();
		logic [7:0] c;
		c = 8'($urandom_range(8'h7E, 8'h21));
		if (c == CH_PERCENT || c == CH_COMMA || c == CH_EQUALS) c = 8'h5F;
		return c;
	endfunction

	function automatic void add_segment(input bit val);
		logic [7:0] c;
		repeat ($urandom_range(3, 1)) begin
			case ($urandom_range(9))
				0, 1, 2, 3: hdr_q.push_back(plain_ch());
				4, 5: begin
					hdr_q.push_back(CH_PERCENT);
					c = 8'($urandom_range(15));
					hdr_q.push_back(hex_ch(c[3:0]));
					c = 8'($urandom_range(15));
					hdr_q.push_back(hex_ch(c[3:0]));
				end
				6: hdr_q.push_back(CH_PERCENT);
				7: begin
					hdr_q.push_back(CH_PERCENT);
					c = 8'($urandom_range(15));
					hdr_q.push_back(hex_ch(c[3:0]));
				end
				8: begin
					c = 8'($urandom_range(255));
					if (c == CH_COMMA || c == CH_EQUALS) c = c ^ 8'h01;
					hdr_q.push_back(c);
				end
				default: hdr_q.push_back(val ? CH_EQUALS : CH_PERCENT);
			endcase
		end
	endfunction

	// Mostly well-formed headers; about one in six ends in a broken tail.
	function automatic void build_header();
		bit good;
		int pairs;
		hdr_q.delete();
		good = ($urandom_range(5) != 0);
		pairs = good ? $urandom_range(3, 1) : $urandom_range(2);
		for (int i = 0; i < pairs; i++) begin
			if (i > 0) hdr_q.push_back(CH_COMMA);
			add_segment(1'b0);
			hdr_q.push_back(CH_EQUALS);
			add_segment(1'b1);
		end
		if (good) begin
			if ($urandom_range(3) == 0) hdr_q.push_back(CH_COMMA);
		end else begin
			if (pairs > 0) hdr_q.push_back(CH_COMMA);
			case ($urandom_range(5))
				0: begin
					add_segment(1'b0);
					hdr_q.push_back(CH_COMMA);
					add_segment(1'b1);
				end
				1: begin
					hdr_q.push_back(CH_EQUALS);
					add_segment(1'b1);
				end
				2: begin
					add_segment(1'b0);
					hdr_q.push_back(CH_EQUALS);
					hdr_q.push_back(CH_COMMA);
					add_segment(1'b0);
				end
				3: add_segment(1'b0);
				4: begin
					add_segment(1'b0);
					hdr_q.push_back(CH_EQUALS);
				end
				default: repeat ($urandom_range(8, 1)) hdr_q.push_back(8'($urandom_range(255)));
			endcase
		end
	endfunction

	initial begin
		beat_t seen;
		bit avail;
		int hold_left;
		bit long_hold_done;
		hold_left = 0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			avail = !empty;
			seen = '{data: out_byte, present: byte_present, inval: in_value,
				pair: pair_done, hdr: header_done, mal: malformed};
			@(posedge clk);
			if (pop && avail) sb.check_beat(seen);
			// One long hold-off lets the queue fill up and push back on the input.
			if (idle_mode == 2 && !long_hold_done) begin
				hold_left = 150;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data_byte = 8'h00;
		end_of_header = 1'b0;
		send_idle = 27;
		recv_idle = 48;
		idle_mode = 0;
		beats_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A lower case escape, lone and doubled percent signs, an equals sign
		// inside a value and a trailing comma that flushes a held upper case escape.
		send_text("%4a%=%%x%2=%5%A,");
		send_beat(8'h00, 1'b0);
		send_beat(CH_EQUALS, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(CH_PERCENT, 1'b1);
		send_text("=");
		send_text(",a");
		send_text("k");
		send_text("a=,b");

		while (beats_sent < 210) begin
			if (beats_sent >= 140) begin
				idle_mode = 2;
				send_idle = 0;
				recv_idle = 0;
			end else if (beats_sent >= 70) begin
				idle_mode = 1;
				send_idle = 48;
				recv_idle = 27;
			end
			build_header();
			foreach (hdr_q[i]) send_beat(hdr_q[i], i == hdr_q.size() - 1);
		end
		push <= 1'b0;

		while (sb.expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
